// ===== hdl/jbdev_pkg.sv =====
// shared types, codes and crc helper for the joybus device command handler
package jbdev_pkg;

    localparam logic [15:0] CRC_POLY = 16'h011b;
    localparam logic [7:0] CMD_PROBE = 8'h00;
    localparam logic [7:0] CMD_ORIGIN = 8'h41;
    localparam logic [7:0] CMD_POLL = 8'h40;
    localparam logic [7:0] CMD_META = 8'h3c;
    localparam logic [7:0] META_OK = 8'h3f;
    localparam logic [7:0] META_KO = 8'h03;
    localparam logic [7:0] META_CAT = 8'h01;
    // upgrade handshake steps carried in the second metacomms body byte
    localparam logic [7:0] UPG_OLD = 8'h00;
    localparam logic [7:0] UPG_NEW = 8'h01;
    localparam logic [7:0] UPG_ACCEPT = 8'h02;

    typedef enum logic [2:0] {
        PH_CMD, PH_POLL, PH_MLEN, PH_MBODY, PH_CRCLO, PH_CRCHI
    } phase_t;

    typedef enum logic [1:0] {
        STEP_NONE, STEP_OLD, STEP_NEW
    } step_t;

    typedef enum logic [1:0] {
        KIND_BYTE, KIND_RUMBLE, KIND_REJECT, KIND_PROTO
    } kind_t;

    typedef enum logic [2:0] {
        RSP_PROBE, RSP_ORIGIN, RSP_REPORT, RSP_SINGLE, RSP_CAPS
    } rsp_t;

    // result slots in emission order
    typedef enum logic [2:0] {
        SL_PRE, SL_RESP, SL_CRCLO, SL_CRCHI, SL_SETP, SL_REV
    } slot_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] rsp_byte(input rsp_t sel, input logic [3:0] idx,
                                            input logic [63:0] report,
                                            input logic [7:0] single);
        logic [7:0] r;
        r = 8'h00;
        unique case (sel)
            RSP_PROBE:  r = (idx == 4'd0) ? 8'h09 : ((idx == 4'd2) ? 8'h03 : 8'h00);
            RSP_ORIGIN: r = (idx >= 4'd1 && idx <= 4'd5) ? 8'h80 : 8'h00;
            RSP_REPORT: r = report[8'd63 - {1'b0, idx[2:0], 3'b000} -: 8];
            RSP_SINGLE: r = single;
            RSP_CAPS:   r = (idx == 4'd0) ? 8'h01 : 8'h03;
            default:    r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/joybus_device_command_handler.sv =====
// joybus device command parser and response sequencer
// results are registered, one result per cycle while m_tready allows
// s_tready stays low until the result emitter has sent all results of a word
// a word that causes no result is followed by the next one in the next cycle
// reset: asynchronous active low, parser waits for a command byte in the native protocol
module joybus_device_command_handler
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // rx_byte[7:0], controller_report[71:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // tx_byte[7:0], rumble_on[8], protocol_id[9], zeros
    output logic [1:0]  m_tuser,   // result_kind[1:0]
    output logic        m_tlast
);

    // parser state
    jbdev_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [7:0]  rem_reg, rem_next;
    logic [7:0]  mlen_reg, mlen_next;
    logic [7:0]  head_reg [3];
    logic [7:0]  head_next [3];
    logic [7:0]  psb_reg, psb_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crclo_reg, crclo_next;
    logic        cur_reg, cur_next;
    logic        prev_reg, prev_next;
    logic        stall_reg, stall_next;
    logic        pend_reg, pend_next;
    jbdev_pkg::step_t step_reg, step_next;

    // result descriptor
    logic [5:0]  pres_reg, pres_next;
    jbdev_pkg::kind_t pre_kind_reg, pre_kind_next;
    logic        pre_rumble_reg, pre_rumble_next;
    jbdev_pkg::rsp_t rsel_reg, rsel_next;
    logic [3:0]  rlen_reg, rlen_next;
    logic [7:0]  rbyte_reg, rbyte_next;
    logic [63:0] report_reg;
    logic        p0_reg, p0_next;
    logic        p1_reg, p1_next;
    logic        p2_reg, p2_next;

    // emitter
    logic        busy_reg;
    jbdev_pkg::slot_t slot_reg, slot_after;
    logic [3:0]  idx_reg;
    logic [15:0] ecrc_reg;
    logic        slot_last, more;

    logic        m_tvalid_reg;
    logic [15:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;
    logic        m_tlast_reg;

    logic [7:0]  b;
    logic        accept, out_adv, emit;
    logic        complete, do_exec, do_fin, rej;
    logic [7:0]  third, idx8;
    logic [7:0]  cur_byte;

    assign b        = s_tdata[7:0];
    assign accept   = s_tvalid && s_tready;
    assign s_tready = !busy_reg;
    assign out_adv  = !m_tvalid_reg || m_tready;
    assign emit     = busy_reg && out_adv;

    always_comb
    begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        rem_next   = rem_reg;
        mlen_next  = mlen_reg;
        head_next  = head_reg;
        psb_next   = psb_reg;
        crc_next   = crc_reg;
        crclo_next = crclo_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        stall_next = stall_reg;
        pend_next  = pend_reg;
        step_next  = step_reg;
        complete = 1'b0;
        do_exec  = 1'b0;
        do_fin   = 1'b0;
        rej      = 1'b0;
        third    = 8'h00;
        idx8     = 8'h00;
        pres_next       = 6'b0;
        pre_kind_next   = jbdev_pkg::KIND_REJECT;
        pre_rumble_next = 1'b0;
        rsel_next  = jbdev_pkg::RSP_SINGLE;
        rlen_next  = 4'd0;
        rbyte_next = 8'h00;
        p0_next = cur_reg;
        p1_next = cur_reg;
        p2_next = cur_reg;

        unique case (phase_reg)
            jbdev_pkg::PH_CMD:
            begin
                cmd_next = b;
                crc_next = jbdev_pkg::crc_feed(16'h0000, b);
                if (b == jbdev_pkg::CMD_PROBE || b == jbdev_pkg::CMD_ORIGIN) begin
                    complete = 1'b1;
                end else if (b == jbdev_pkg::CMD_POLL) begin
                    rem_next   = 8'd2;
                    phase_next = jbdev_pkg::PH_POLL;
                end else if (b == jbdev_pkg::CMD_META) begin
                    head_next[0] = 8'h00;
                    head_next[1] = 8'h00;
                    head_next[2] = 8'h00;
                    phase_next = jbdev_pkg::PH_MLEN;
                end else begin
                    rej    = 1'b1;
                    do_fin = 1'b1;
                end
            end
            jbdev_pkg::PH_POLL:
            begin
                crc_next = jbdev_pkg::crc_feed(crc_reg, b);
                if (rem_reg >= 8'd2) begin
                    psb_next = b;
                    rem_next = 8'd1;
                end else begin
                    rem_next   = 8'd0;
                    crclo_next = b;
                    third      = b;
                    complete   = 1'b1;
                end
            end
            jbdev_pkg::PH_MLEN:
            begin
                crc_next  = jbdev_pkg::crc_feed(crc_reg, b);
                mlen_next = b;
                rem_next  = b;
                if (b == 8'd0) complete = 1'b1;
                else phase_next = jbdev_pkg::PH_MBODY;
            end
            jbdev_pkg::PH_MBODY:
            begin
                crc_next = jbdev_pkg::crc_feed(crc_reg, b);
                idx8 = mlen_reg - rem_reg;
                if (idx8 < 8'd3) head_next[idx8[1:0]] = b;
                rem_next = rem_reg - 8'd1;
                if (rem_next == 8'd0) complete = 1'b1;
            end
            jbdev_pkg::PH_CRCLO:
            begin
                if (cmd_reg == jbdev_pkg::CMD_POLL) psb_next = crclo_reg;
                crclo_next = b;
                phase_next = jbdev_pkg::PH_CRCHI;
            end
            jbdev_pkg::PH_CRCHI:
            begin
                if ({b, crclo_reg} != crc_reg) rej = 1'b1;
                else begin
                    do_exec = 1'b1;
                    third   = psb_reg;
                end
                do_fin = 1'b1;
            end
            default:
            begin
                phase_next = jbdev_pkg::PH_CMD;
            end
        endcase

        if (complete) begin
            if (cur_reg) phase_next = jbdev_pkg::PH_CRCLO;
            else begin
                do_exec = 1'b1;
                do_fin  = 1'b1;
            end
        end

        if (rej) begin
            pres_next[jbdev_pkg::SL_PRE] = 1'b1;
            pre_kind_next = jbdev_pkg::KIND_REJECT;
        end

        if (do_exec) begin
            if (cmd_next == jbdev_pkg::CMD_PROBE) begin
                rsel_next = jbdev_pkg::RSP_PROBE;
                rlen_next = 4'd3;
            end else if (cmd_next == jbdev_pkg::CMD_ORIGIN) begin
                rsel_next = jbdev_pkg::RSP_ORIGIN;
                rlen_next = 4'd10;
            end else if (cmd_next == jbdev_pkg::CMD_POLL) begin
                pres_next[jbdev_pkg::SL_PRE] = 1'b1;
                pre_kind_next   = jbdev_pkg::KIND_RUMBLE;
                pre_rumble_next = third[0];
                rsel_next = jbdev_pkg::RSP_REPORT;
                rlen_next = 4'd8;
            end else begin
                rsel_next = jbdev_pkg::RSP_SINGLE;
                rlen_next = 4'd1;
                rbyte_next = jbdev_pkg::META_KO;
                if (mlen_next == 8'd0) begin
                    rbyte_next = jbdev_pkg::META_CAT;
                end else if (head_next[0] != 8'h00) begin
                    rbyte_next = jbdev_pkg::META_KO;
                end else if (mlen_next == 8'd1) begin
                    rsel_next = jbdev_pkg::RSP_CAPS;
                    rlen_next = 4'd2;
                end else if (mlen_next < 8'd3 || head_next[2] >= 8'd2) begin
                    rbyte_next = jbdev_pkg::META_KO;
                end else begin
                    case (head_next[1])
                        jbdev_pkg::UPG_OLD:
                        begin
                            rbyte_next = jbdev_pkg::META_OK;
                            stall_next = 1'b1;
                            pend_next  = 1'b1;
                            step_next  = jbdev_pkg::STEP_OLD;
                            prev_next  = cur_reg;
                            cur_next   = head_next[2][0];
                            pres_next[jbdev_pkg::SL_SETP] = 1'b1;
                        end
                        jbdev_pkg::UPG_NEW:
                        begin
                            if (step_reg == jbdev_pkg::STEP_OLD) begin
                                rbyte_next = jbdev_pkg::META_OK;
                                stall_next = 1'b1;
                                step_next  = jbdev_pkg::STEP_NEW;
                            end
                        end
                        jbdev_pkg::UPG_ACCEPT:
                        begin
                            if (step_reg == jbdev_pkg::STEP_NEW) begin
                                rbyte_next = jbdev_pkg::META_OK;
                                pend_next  = 1'b0;
                            end
                            step_next = jbdev_pkg::STEP_NONE;
                        end
                        default:
                        begin
                            rbyte_next = jbdev_pkg::META_KO;
                        end
                    endcase
                end
            end
            pres_next[jbdev_pkg::SL_RESP]  = 1'b1;
            pres_next[jbdev_pkg::SL_CRCLO] = cur_reg;
            pres_next[jbdev_pkg::SL_CRCHI] = cur_reg;
        end
        p1_next = cur_next;
        p2_next = cur_next;

        if (do_fin) begin
            if (!stall_next && pend_next) begin
                prev_next = cur_next;
                cur_next  = prev_reg;
                p2_next   = prev_reg;
                step_next = jbdev_pkg::STEP_NONE;
                pend_next = 1'b0;
                pres_next[jbdev_pkg::SL_REV] = 1'b1;
            end
            stall_next = 1'b0;
            phase_next = jbdev_pkg::PH_CMD;
        end
    end

    // next present slot after the current one
    always_comb
    begin
        slot_after = jbdev_pkg::SL_PRE;
        more = 1'b0;
        for (int i = 5; i >= 0; i--) begin
            if (pres_reg[i] && 3'(i) > slot_reg) begin
                slot_after = jbdev_pkg::slot_t'(3'(i));
                more = 1'b1;
            end
        end
        slot_last = !more &&
                    !(slot_reg == jbdev_pkg::SL_RESP && idx_reg != rlen_reg - 4'd1);
    end

    assign cur_byte = jbdev_pkg::rsp_byte(rsel_reg, idx_reg, report_reg, rbyte_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= jbdev_pkg::PH_CMD;
            cmd_reg   <= 8'h00;
            rem_reg   <= 8'h00;
            mlen_reg  <= 8'h00;
            head_reg[0] <= 8'h00;
            head_reg[1] <= 8'h00;
            head_reg[2] <= 8'h00;
            psb_reg   <= 8'h00;
            crc_reg   <= 16'h0000;
            crclo_reg <= 8'h00;
            cur_reg   <= 1'b0;
            prev_reg  <= 1'b0;
            stall_reg <= 1'b0;
            pend_reg  <= 1'b0;
            step_reg  <= jbdev_pkg::STEP_NONE;
            busy_reg  <= 1'b0;
            pres_reg  <= 6'b0;
            slot_reg  <= jbdev_pkg::SL_PRE;
            idx_reg   <= 4'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg <= phase_next;
                cmd_reg   <= cmd_next;
                rem_reg   <= rem_next;
                mlen_reg  <= mlen_next;
                head_reg  <= head_next;
                psb_reg   <= psb_next;
                crc_reg   <= crc_next;
                crclo_reg <= crclo_next;
                cur_reg   <= cur_next;
                prev_reg  <= prev_next;
                stall_reg <= stall_next;
                pend_reg  <= pend_next;
                step_reg  <= step_next;
                pres_reg  <= pres_next;
                busy_reg  <= pres_next != 6'b0;
                idx_reg   <= 4'd0;
                slot_reg  <= jbdev_pkg::SL_PRE;
                for (int i = 5; i >= 0; i--) begin
                    if (pres_next[i]) slot_reg <= jbdev_pkg::slot_t'(3'(i));
                end
            end else if (emit) begin
                if (slot_reg == jbdev_pkg::SL_RESP && idx_reg != rlen_reg - 4'd1) begin
                    idx_reg <= idx_reg + 4'd1;
                end else begin
                    slot_reg <= slot_after;
                    busy_reg <= more;
                end
            end
            if (emit) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
        end
    end

    // descriptor and result payload
    always_ff @(posedge clk)
    begin
        if (accept) begin
            pre_kind_reg   <= pre_kind_next;
            pre_rumble_reg <= pre_rumble_next;
            rsel_reg   <= rsel_next;
            rlen_reg   <= rlen_next;
            rbyte_reg  <= rbyte_next;
            report_reg <= s_tdata[71:8];
            p0_reg <= p0_next;
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            ecrc_reg <= 16'h0000;
        end else if (emit && slot_reg == jbdev_pkg::SL_RESP) begin
            ecrc_reg <= jbdev_pkg::crc_feed(ecrc_reg, cur_byte);
        end
        if (emit) begin
            m_tlast_reg <= slot_last;
            unique case (slot_reg)
                jbdev_pkg::SL_PRE:
                begin
                    m_tuser_reg <= pre_kind_reg;
                    m_tdata_reg <= {6'b0, p0_reg, pre_rumble_reg, 8'h00};
                end
                jbdev_pkg::SL_RESP:
                begin
                    m_tuser_reg <= jbdev_pkg::KIND_BYTE;
                    m_tdata_reg <= {6'b0, p0_reg, 1'b0, cur_byte};
                end
                jbdev_pkg::SL_CRCLO:
                begin
                    m_tuser_reg <= jbdev_pkg::KIND_BYTE;
                    m_tdata_reg <= {6'b0, p0_reg, 1'b0, ecrc_reg[7:0]};
                end
                jbdev_pkg::SL_CRCHI:
                begin
                    m_tuser_reg <= jbdev_pkg::KIND_BYTE;
                    m_tdata_reg <= {6'b0, p0_reg, 1'b0, ecrc_reg[15:8]};
                end
                jbdev_pkg::SL_SETP:
                begin
                    m_tuser_reg <= jbdev_pkg::KIND_PROTO;
                    m_tdata_reg <= {6'b0, p1_reg, 9'h000};
                end
                default:
                begin
                    m_tuser_reg <= jbdev_pkg::KIND_PROTO;
                    m_tdata_reg <= {6'b0, p2_reg, 9'h000};
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ===== hdl/jbdev_checker.sv =====
// port-level checks for the joybus device command handler
module jbdev_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [71:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_byte_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != jbdev_pkg::KIND_BYTE |-> m_tdata[7:0] == 8'h00)
        else $error("tx byte set on a non-byte result");

    a_rumble_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != jbdev_pkg::KIND_RUMBLE |-> !m_tdata[8])
        else $error("rumble set on a non-rumble result");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:10] == 6'd0)
        else $error("padding bits not zero");

    // a new rx word is only taken once the previous burst has been fully emitted
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> (!m_tvalid || m_tlast) && !$isunknown(s_tdata))
        else $error("rx word accepted while results still pending");

endmodule

bind joybus_device_command_handler jbdev_checker u_jbdev_checker (.*);

// ===== bench/tb_joybus_device_command_handler.sv =====
// testbench for the joybus device command handler: directed and random command streams

typedef struct packed {
    jbdev_pkg::kind_t kind;
    logic [7:0] tx;
    logic       lst;
    logic       rumble;
    logic       proto;
} jb_result_t;

class jb_scoreboard;
    jb_result_t pending[$];
    int         errors;
    // responder model state
    jbdev_pkg::phase_t phase;
    logic [7:0] cmd;
    logic [7:0] remaining;
    logic [7:0] mlen;
    logic [7:0] head[3];
    logic [7:0] poll_arg;
    logic [15:0] crc;
    logic [7:0] crc_lo;
    logic       cur_proto;
    logic       prev_proto;
    logic       stall;
    logic       revert;
    jbdev_pkg::step_t step;
    jb_result_t burst[$];

    function new();
        errors = 0;
        phase = jbdev_pkg::PH_CMD;
        cmd = 8'h00;
        remaining = 8'h00;
        mlen = 8'h00;
        head = '{8'h00, 8'h00, 8'h00};
        poll_arg = 8'h00;
        crc = 16'h0000;
        crc_lo = 8'h00;
        cur_proto = 1'b0;
        prev_proto = 1'b0;
        stall = 1'b0;
        revert = 1'b0;
        step = jbdev_pkg::STEP_NONE;
    endfunction

    function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
            r = r[15] ? ((r << 1) ^ jbdev_pkg::CRC_POLY) : (r << 1);
        return r;
    endfunction

    function void push(jbdev_pkg::kind_t k, logic [7:0] b, logic rum);
        jb_result_t r;
        r.kind = k;
        r.tx = b;
        r.lst = 1'b0;
        r.rumble = rum;
        r.proto = cur_proto;
        burst.push_back(r);
    endfunction

    function void answer(logic [7:0] bytes[$]);
        logic [15:0] c;
        c = 16'h0000;
        foreach (bytes[i])
        begin
            push(jbdev_pkg::KIND_BYTE, bytes[i], 1'b0);
            c = crc_step(c, bytes[i]);
        end
        if (cur_proto)
        begin
            push(jbdev_pkg::KIND_BYTE, c[7:0], 1'b0);
            push(jbdev_pkg::KIND_BYTE, c[15:8], 1'b0);
        end
    endfunction

    function void switch_proto(logic id);
        prev_proto = cur_proto;
        cur_proto = id;
        push(jbdev_pkg::KIND_PROTO, 8'h00, 1'b0);
    endfunction

    function void upgrade_request();
        if (mlen == 8'd0) begin answer('{jbdev_pkg::META_CAT}); return; end
        if (head[0] != 8'h00) begin answer('{jbdev_pkg::META_KO}); return; end
        if (mlen == 8'd1) begin answer('{8'h01, 8'h03}); return; end
        if (mlen < 8'd3 || head[2] >= 8'd2) begin answer('{jbdev_pkg::META_KO}); return; end
        case (head[1])
            jbdev_pkg::UPG_OLD:
            begin
                answer('{jbdev_pkg::META_OK});
                stall = 1'b1;
                revert = 1'b1;
                step = jbdev_pkg::STEP_OLD;
                switch_proto(head[2][0]);
            end
            jbdev_pkg::UPG_NEW:
                if (step == jbdev_pkg::STEP_OLD)
                begin
                    answer('{jbdev_pkg::META_OK});
                    stall = 1'b1;
                    step = jbdev_pkg::STEP_NEW;
                end
                else
                    answer('{jbdev_pkg::META_KO});
            jbdev_pkg::UPG_ACCEPT:
            begin
                if (step == jbdev_pkg::STEP_NEW)
                begin
                    answer('{jbdev_pkg::META_OK});
                    revert = 1'b0;
                end
                else
                    answer('{jbdev_pkg::META_KO});
                step = jbdev_pkg::STEP_NONE;
            end
            default: answer('{jbdev_pkg::META_KO});
        endcase
    endfunction

    function void run_command(logic [63:0] rep, logic [7:0] arg);
        logic [7:0] bytes[$];
        case (cmd)
            jbdev_pkg::CMD_PROBE: answer('{8'h09, 8'h00, 8'h03});
            jbdev_pkg::CMD_ORIGIN: answer('{8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
                                            8'h00, 8'h00, 8'h00, 8'h00});
            jbdev_pkg::CMD_POLL:
            begin
                push(jbdev_pkg::KIND_RUMBLE, 8'h00, arg[0]);
                for (int i = 0; i < 8; i++) bytes.push_back(rep[63 - 8 * i -: 8]);
                answer(bytes);
            end
            default: upgrade_request();
        endcase
    endfunction

    function void close_command();
        if (!stall && revert)
        begin
            switch_proto(prev_proto);
            step = jbdev_pkg::STEP_NONE;
            revert = 1'b0;
        end
        stall = 1'b0;
        phase = jbdev_pkg::PH_CMD;
    endfunction

    function void command_done(logic [63:0] rep, logic [7:0] arg);
        if (cur_proto) begin phase = jbdev_pkg::PH_CRCLO; return; end
        run_command(rep, arg);
        close_command();
    endfunction

    // notes an accepted rx word and queues the results it causes
    function void note_rx(logic [7:0] b, logic [63:0] rep);
        logic [7:0] idx;
        burst.delete();
        case (phase)
            jbdev_pkg::PH_CMD:
            begin
                cmd = b;
                crc = crc_step(16'h0000, b);
                if (b == jbdev_pkg::CMD_PROBE || b == jbdev_pkg::CMD_ORIGIN)
                    command_done(rep, 8'h00);
                else if (b == jbdev_pkg::CMD_POLL)
                begin
                    remaining = 8'd2;
                    phase = jbdev_pkg::PH_POLL;
                end
                else if (b == jbdev_pkg::CMD_META)
                begin
                    head = '{8'h00, 8'h00, 8'h00};
                    phase = jbdev_pkg::PH_MLEN;
                end
                else
                begin
                    push(jbdev_pkg::KIND_REJECT, 8'h00, 1'b0);
                    close_command();
                end
            end
            jbdev_pkg::PH_POLL:
            begin
                crc = crc_step(crc, b);
                if (remaining >= 8'd2) begin poll_arg = b; remaining = 8'd1; end
                else
                begin
                    remaining = 8'd0;
                    crc_lo = b;
                    command_done(rep, b);
                end
            end
            jbdev_pkg::PH_MLEN:
            begin
                crc = crc_step(crc, b);
                mlen = b;
                remaining = b;
                if (b == 8'd0) command_done(rep, 8'h00);
                else phase = jbdev_pkg::PH_MBODY;
            end
            jbdev_pkg::PH_MBODY:
            begin
                crc = crc_step(crc, b);
                idx = mlen - remaining;
                if (idx < 8'd3) head[idx[1:0]] = b;
                remaining = remaining - 8'd1;
                if (remaining == 8'd0) command_done(rep, 8'h00);
            end
            jbdev_pkg::PH_CRCLO:
            begin
                if (cmd == jbdev_pkg::CMD_POLL) poll_arg = crc_lo;
                crc_lo = b;
                phase = jbdev_pkg::PH_CRCHI;
            end
            default:
            begin
                if ({b, crc_lo} != crc) push(jbdev_pkg::KIND_REJECT, 8'h00, 1'b0);
                else run_command(rep, poll_arg);
                close_command();
            end
        endcase
        if (burst.size() > 0) burst[burst.size() - 1].lst = 1'b1;
        foreach (burst[i]) pending.push_back(burst[i]);
    endfunction

    function void check_result(logic [15:0] d, logic [1:0] u, logic l);
        jb_result_t e;
        if (pending.size() == 0)
        begin
            $error("unexpected result word kind=%0d tx=%h", u, d[7:0]);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (u != e.kind) begin $error("kind exp %0d got %0d", e.kind, u); errors++; end
        if (d[7:0] != e.tx) begin $error("tx_byte exp %h got %h", e.tx, d[7:0]); errors++; end
        if (l != e.lst) begin $error("last exp %0d got %0d", e.lst, l); errors++; end
        if (d[8] != e.rumble)
        begin
            $error("rumble_on exp %0d got %0d", e.rumble, d[8]);
            errors++;
        end
        if (d[9] != e.proto)
        begin
            $error("protocol_id exp %0d got %0d", e.proto, d[9]);
            errors++;
        end
        if (d[15:10] != 6'd0) begin $error("pad exp 0 got %h", d[15:10]); errors++; end
    endfunction

    // crc the host must append to the bytes sent since the command byte
    function logic [15:0] host_crc();
        return crc;
    endfunction
endclass

module tb_joybus_device_command_handler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    jb_scoreboard board;
    int          idle_cycles = 0;
    logic        timed_out = 1'b0;
    logic        sink_busy;

    joybus_device_command_handler uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // random 64-bit controller report
    function logic [63:0] rand_report();
        return {$urandom(), $urandom()};
    endfunction

    // valid stays up between back to back words and drops only for a gap
    task automatic send_word(logic [7:0] b, int gap);
        logic [63:0] rep;
        rep = rand_report();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {rep, b};
        do @(posedge clk); while (!s_tready);
        board.note_rx(b, rep);
    endtask

    task automatic send_byte(logic [7:0] b, bit quiet);
        send_word(b, quiet ? 0 : gap_len());
    endtask

    // adds the crc trailer when the fast protocol is active
    task automatic send_cmd(logic [7:0] bytes[$], bit bad_crc, bit quiet);
        logic [15:0] c;
        foreach (bytes[i]) send_byte(bytes[i], quiet);
        if (board.phase == jbdev_pkg::PH_CRCLO)
        begin
            c = board.host_crc();
            if (bad_crc) c ^= 16'h1 << $urandom_range(0, 15);
            send_byte(c[7:0], quiet);
            send_byte(c[15:8], quiet);
        end
    endtask

    task automatic upgrade(logic [7:0] op, logic [7:0] proto, bit quiet);
        send_cmd('{jbdev_pkg::CMD_META, 8'd3, 8'd0, op, proto}, 0, quiet);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0 && !timed_out) @(posedge clk);
    endtask

    task automatic random_command(bit quiet);
        logic [7:0] q[$];
        int         r;
        int         n;
        r = $urandom_range(0, 99);
        if (r < 15) send_cmd('{jbdev_pkg::CMD_PROBE}, $urandom_range(0, 9) == 0, quiet);
        else if (r < 25) send_cmd('{jbdev_pkg::CMD_ORIGIN}, $urandom_range(0, 9) == 0, quiet);
        else if (r < 50)
            send_cmd('{jbdev_pkg::CMD_POLL, 8'($urandom()), 8'($urandom())},
                     $urandom_range(0, 9) == 0, quiet);
        else if (r < 80)
        begin
            // handshake steps with mostly legal arguments
            upgrade(8'($urandom_range(0, 3)), $urandom_range(0, 3) == 0 ? 8'($urandom()) :
                    8'($urandom_range(0, 1)), quiet);
        end
        else if (r < 90)
        begin
            n = $urandom_range(0, 3) == 0 ? $urandom_range(0, 12) : $urandom_range(0, 4);
            q.push_back(jbdev_pkg::CMD_META);
            q.push_back(8'(n));
            for (int i = 0; i < n; i++)
                q.push_back($urandom_range(0, 1) ? 8'($urandom()) : 8'($urandom_range(0, 2)));
            send_cmd(q, $urandom_range(0, 9) == 0, quiet);
        end
        else send_byte(8'($urandom()), quiet);
    endtask

    // result sink with random backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                board.check_result(m_tdata, m_tuser, m_tlast);
            m_tready <= sink_busy ? 1'b0 : 1'b1;
        end
    end

    initial
    begin
        int g;
        sink_busy = 0;
        @(posedge rst_n);
        forever
        begin
            g = gap_len();
            if (g > 0)
            begin
                sink_busy = 1;
                repeat (g) @(posedge clk);
            end
            sink_busy = 0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT && !timed_out)
            begin
                timed_out = 1;
                $display("tb_joybus_device_command_handler failed");
                $finish;
            end
        end
    end

    initial
    begin
        board = new();
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: each command in the native protocol
        send_cmd('{jbdev_pkg::CMD_PROBE}, 0, 1);
        send_cmd('{jbdev_pkg::CMD_ORIGIN}, 0, 1);
        send_cmd('{jbdev_pkg::CMD_POLL, 8'h03, 8'h01}, 0, 1);
        send_cmd('{jbdev_pkg::CMD_POLL, 8'hff, 8'hfe}, 0, 1);
        send_cmd('{8'hff}, 0, 1);
        send_cmd('{jbdev_pkg::CMD_META, 8'd0}, 0, 1);
        send_cmd('{jbdev_pkg::CMD_META, 8'd1, 8'd0}, 0, 1);
        send_cmd('{jbdev_pkg::CMD_META, 8'd1, 8'd5}, 0, 1);
        send_cmd('{jbdev_pkg::CMD_META, 8'd2, 8'd0, 8'd0}, 0, 1);
        upgrade(jbdev_pkg::UPG_OLD, 8'd2, 1);
        upgrade(jbdev_pkg::UPG_NEW, 8'd1, 1);
        upgrade(jbdev_pkg::UPG_ACCEPT, 8'd1, 1);
        // full upgrade to fast, then commands with crc trailers
        upgrade(jbdev_pkg::UPG_OLD, 8'd1, 1);
        upgrade(jbdev_pkg::UPG_NEW, 8'd1, 1);
        upgrade(jbdev_pkg::UPG_ACCEPT, 8'd1, 1);
        send_cmd('{jbdev_pkg::CMD_POLL, 8'h00, 8'h01}, 0, 1);
        send_cmd('{jbdev_pkg::CMD_PROBE}, 1, 1);
        send_cmd('{8'h55}, 0, 1);
        // incomplete upgrade reverts on the next command
        upgrade(jbdev_pkg::UPG_OLD, 8'd0, 1);
        send_cmd('{jbdev_pkg::CMD_ORIGIN}, 0, 1);
        upgrade(8'd7, 8'd0, 1);
        send_cmd('{jbdev_pkg::CMD_META, 8'd30}, 0, 1);
        for (int i = 0; i < 30; i++) send_byte(8'($urandom()), 1);
        drain();

        for (int i = 0; i < 60 && !timed_out; i++)
        begin
            random_command($urandom_range(0, 4) == 0);
            if (i % 40 == 20) drain();
        end
        drain();
        repeat (20) @(posedge clk);

        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb_joybus_device_command_handler passed");
        else
        begin
            if (board.pending.size() != 0)
                $error("%0d expected results never arrived", board.pending.size());
            $display("tb_joybus_device_command_handler failed");
        end
        $finish;
    end
endmodule
